@@ hdl/lskvm_pkg.sv @@
// Shared constants, codes and control/status types of the key-value map.
`default_nettype none

package lskvm_pkg;

    // Default sizing of the table
    localparam int CAPACITY_DEF    = 64;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int CMD_W        = 3;
    localparam int KEY_PORT_W   = 32;
    localparam int VALUE_PORT_W = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_PORT_W = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_GET   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // take a new item
        logic scan;    // walk the table looking for the key
        logic update;  // apply the command after the search
        logic shift;   // move later entries down after an erase
        logic reply;   // register the result
    } ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic start_search;  // the item on the input ports needs a search
        logic is_erase;      // the held item is an erase
        logic hit;           // key matched this cycle
        logic miss;          // table walked without a match
        logic shift_done;    // last entry moved
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/lskvm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lskvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/lskvm_ctrl.sv @@
// Controller state machine of the key-value map.
`default_nettype none

module lskvm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire lskvm_pkg::sts_t sts,
    output lskvm_pkg::ctl_t     ctl,
    output logic                busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_UPDATE = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_REPLY  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = sts.start_search ? S_SEARCH : S_REPLY;
                end
            end
            S_SEARCH:
            begin
                ctl.scan = 1'b1;
                if (sts.hit)
                begin
                    state_next = sts.is_erase ? S_SHIFT : S_UPDATE;
                end
                else if (sts.miss)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                ctl.update = 1'b1;
                state_next = S_REPLY;
            end
            S_SHIFT:
            begin
                ctl.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                ctl.reply  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ hdl/lskvm_dp.sv @@
// Datapath of the key-value map: item registers, scan counter, tables, result.
`default_nettype none

module lskvm_dp #(
    parameter int CAPACITY    = lskvm_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = lskvm_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lskvm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lskvm_pkg::ctl_t                    ctl,
    output lskvm_pkg::sts_t                         sts,
    input  wire logic [lskvm_pkg::CMD_W-1:0]        command,
    input  wire logic [lskvm_pkg::KEY_PORT_W-1:0]   key,
    input  wire logic [lskvm_pkg::VALUE_PORT_W-1:0] value_in,
    output logic                                    done,
    output logic [lskvm_pkg::VALUE_PORT_W-1:0]      value_out,
    output logic                                    found,
    output logic [lskvm_pkg::STATUS_W-1:0]          status,
    output logic [lskvm_pkg::COUNT_PORT_W-1:0]      entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KPW = lskvm_pkg::KEY_PORT_W;
    localparam int VPW = lskvm_pkg::VALUE_PORT_W;
    localparam int NPW = lskvm_pkg::COUNT_PORT_W;

    // Held item
    logic [lskvm_pkg::CMD_W-1:0] cmd_reg;
    logic [KEY_WIDTH-1:0]        key_reg;
    logic [VALUE_WIDTH-1:0]      vin_reg;

    // Table state and scan
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               scan_idx_reg;
    logic                        rd_valid_reg;
    logic                        hit_reg;
    logic [AW-1:0]               pos_reg;
    logic [VALUE_WIDTH-1:0]      res_val_reg;
    logic [lskvm_pkg::STATUS_W-1:0] res_status_reg;

    // Result registers
    logic                        done_reg;
    logic [VPW-1:0]              value_out_reg;
    logic                        found_reg;
    logic [lskvm_pkg::STATUS_W-1:0] status_reg;
    logic [NPW-1:0]              entry_count_reg;

    // Width adaptation
    logic [KEY_WIDTH+KPW-1:0]    key_ext;
    logic [VALUE_WIDTH+VPW-1:0]  vin_ext;
    logic [VALUE_WIDTH+VPW-1:0]  res_ext;
    logic [CW+NPW-1:0]           count_ext;
    logic [KEY_WIDTH-1:0]        key_in;
    logic [VALUE_WIDTH-1:0]      vin_in;

    // Memory ports
    logic                        key_we;
    logic                        val_we;
    logic [AW-1:0]               waddr;
    logic [KEY_WIDTH-1:0]        key_wdata;
    logic [VALUE_WIDTH-1:0]      val_wdata;
    logic [AW-1:0]               raddr;
    logic [KEY_WIDTH-1:0]        key_rdata;
    logic [VALUE_WIDTH-1:0]      val_rdata;

    // Scan helpers
    logic [CW-1:0]               prev_idx;
    logic [CW-1:0]               shift_dst;
    logic                        hit_now;
    logic                        more;
    logic                        full;
    logic                        is_insert;

    assign key_ext   = {{KEY_WIDTH{1'b0}}, key};
    assign vin_ext   = {{VALUE_WIDTH{1'b0}}, value_in};
    assign key_in    = key_ext[KEY_WIDTH-1:0];
    assign vin_in    = vin_ext[VALUE_WIDTH-1:0];
    assign res_ext   = {{VPW{1'b0}}, res_val_reg};
    assign count_ext = {{NPW{1'b0}}, count_reg};

    assign prev_idx  = scan_idx_reg - CW'(1);
    assign shift_dst = scan_idx_reg - CW'(2);
    assign hit_now   = rd_valid_reg && (key_rdata == key_reg);
    assign more      = (scan_idx_reg < count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign is_insert = (cmd_reg == lskvm_pkg::CMD_GET) || (cmd_reg == lskvm_pkg::CMD_PUT);

    // Status toward the controller
    always_comb
    begin
        sts.start_search = (command == lskvm_pkg::CMD_GET) ||
                           (command == lskvm_pkg::CMD_PUT) ||
                           (command == lskvm_pkg::CMD_ERASE) ||
                           (command == lskvm_pkg::CMD_PEEK);
        sts.is_erase     = (cmd_reg == lskvm_pkg::CMD_ERASE);
        sts.hit          = hit_now;
        sts.miss         = !hit_now && !more;
        sts.shift_done   = !rd_valid_reg && !more;
    end

    // Read always follows the scan index; write for update, append or shift
    assign raddr = scan_idx_reg[AW-1:0];

    always_comb
    begin
        key_we    = 1'b0;
        val_we    = 1'b0;
        waddr     = pos_reg;
        key_wdata = key_reg;
        val_wdata = vin_reg;
        if (ctl.update)
        begin
            if (hit_reg)
            begin
                val_we = (cmd_reg == lskvm_pkg::CMD_PUT);
            end
            else if (is_insert && !full)
            begin
                key_we    = 1'b1;
                val_we    = 1'b1;
                waddr     = count_reg[AW-1:0];
                val_wdata = (cmd_reg == lskvm_pkg::CMD_PUT) ? vin_reg : '0;
            end
        end
        else if (ctl.shift && rd_valid_reg)
        begin
            key_we    = 1'b1;
            val_we    = 1'b1;
            waddr     = shift_dst[AW-1:0];
            key_wdata = key_rdata;
            val_wdata = val_rdata;
        end
    end

    lskvm_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (key_wdata),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    lskvm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (waddr),
        .wdata (val_wdata),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.reply;
            if (ctl.load)
            begin
                rd_valid_reg <= 1'b0;
                if (command == lskvm_pkg::CMD_CLEAR)
                begin
                    count_reg <= '0;
                end
            end
            else if (ctl.scan)
            begin
                rd_valid_reg <= !hit_now && more;
            end
            else if (ctl.shift)
            begin
                rd_valid_reg <= more;
                if (!rd_valid_reg && !more)
                begin
                    count_reg <= count_reg - CW'(1);
                end
            end
            else if (ctl.update)
            begin
                if (!hit_reg && is_insert && !full)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg        <= command;
            key_reg        <= key_in;
            vin_reg        <= vin_in;
            scan_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            res_val_reg    <= '0;
            res_status_reg <= lskvm_pkg::ST_OK;
        end
        else if (ctl.scan)
        begin
            if (hit_now)
            begin
                hit_reg     <= 1'b1;
                pos_reg     <= prev_idx[AW-1:0];
                res_val_reg <= val_rdata;
            end
            else if (more)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
        end
        else if (ctl.shift)
        begin
            if (more)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
        end
        else if (ctl.update)
        begin
            if (hit_reg)
            begin
                if (cmd_reg == lskvm_pkg::CMD_PUT)
                begin
                    res_val_reg <= vin_reg;
                end
            end
            else if (is_insert)
            begin
                if (full)
                begin
                    res_status_reg <= lskvm_pkg::ST_FULL;
                end
                else if (cmd_reg == lskvm_pkg::CMD_PUT)
                begin
                    res_val_reg <= vin_reg;
                end
            end
            else if (cmd_reg == lskvm_pkg::CMD_ERASE)
            begin
                res_status_reg <= lskvm_pkg::ST_NOT_FOUND;
            end
        end

        if (ctl.reply)
        begin
            value_out_reg   <= res_ext[VPW-1:0];
            found_reg       <= hit_reg;
            status_reg      <= res_status_reg;
            entry_count_reg <= count_ext[NPW-1:0];
        end
    end

    assign done        = done_reg;
    assign value_out   = value_out_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

@@ hdl/linear_search_key_value_map_top.sv @@
// Top level of the linear-search key-value map: controller plus datapath.
//
// Usage:
//   Input channel: drive command, key and value_in and raise start; the item
//   is taken at the rising edge where start is high and busy is low. busy
//   stays high while the item is being worked on.
//   Result channel: done is high for exactly one cycle, with value_out,
//   found, status and entry_count valid in that same cycle. The receiver
//   cannot stall; take the result in that cycle or lose it. busy is already
//   low in the done cycle, so the next item may be started there.
// Sequence:
//   clear and unused codes: from the accepting edge straight to the reply step.
//   get, put, peek, erase miss: a scan reading one table entry per cycle,
//   then an update step and a reply step.
//   erase hit: a scan up to the key, then the shift state, which moves the
//   later entries down one slot each, and a reply step.
//   One item is in flight at a time; the single read port of each table
//   sets the rate at about one entry per cycle.
// Reset: rst_n clears the entry count and the controller; the table RAMs are
// not cleared, since only entries below the count are ever used.
`default_nettype none

module linear_search_key_value_map_top #(
    parameter int CAPACITY    = lskvm_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = lskvm_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lskvm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [lskvm_pkg::CMD_W-1:0]        command,
    input  wire logic [lskvm_pkg::KEY_PORT_W-1:0]   key,
    input  wire logic [lskvm_pkg::VALUE_PORT_W-1:0] value_in,
    output logic                                    done,
    output logic [lskvm_pkg::VALUE_PORT_W-1:0]      value_out,
    output logic                                    found,
    output logic [lskvm_pkg::STATUS_W-1:0]          status,
    output logic [lskvm_pkg::COUNT_PORT_W-1:0]      entry_count
);

    lskvm_pkg::ctl_t ctl;
    lskvm_pkg::sts_t sts;

    // Sequence the search, update, shift and reply steps
    lskvm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Hold the item, walk the tables and build the result
    lskvm_dp #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .command     (command),
        .key         (key),
        .value_in    (value_in),
        .done        (done),
        .value_out   (value_out),
        .found       (found),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire

@@ tb/linear_search_key_value_map_top_tb.sv @@
// Self-checking testbench for the linear-search key-value map top level.
`default_nettype none

module linear_search_key_value_map_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lskvm_pkg::*;

    // Table depth of the instance under test (default parameters).
    localparam int DEPTH = CAPACITY_DEF;

    // Start no new episode once this many items have been accepted.
    localparam int N_ITEMS = 1600;

    // Command codes the block treats as no-ops.
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int MAX_REPORTS = 10;

    // One result item as seen on the output ports.
    typedef struct packed {
        logic [VALUE_PORT_W-1:0] value;
        logic                    found;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_PORT_W-1:0] count;
    } reply_t;

    // One directed row; when 'typed' is set, 'reply' is the result to expect,
    // otherwise the shadow table decides.
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [KEY_PORT_W-1:0]   key;
        logic [VALUE_PORT_W-1:0] value;
        logic                    typed;
        reply_t                  reply;
    } plan_row_t;

    localparam int N_PLAN = 24;

    // Directed opening: empty-table lookups, extreme keys and values, every
    // command, the spare codes, erase at the middle, tail and head of the
    // table, erase of a missing key, and clear.
    localparam plan_row_t PLAN [N_PLAN] = '{
        '{CMD_PEEK,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 1'b0, ST_OK,        7'd0}},
        '{CMD_ERASE,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, 1'b0, ST_NOT_FOUND, 7'd0}},
        '{CMD_GET,     32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, 1'b0, ST_OK,        7'd1}},
        '{CMD_PUT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 1'b0, ST_OK,        7'd2}},
        '{CMD_GET,     32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{32'hFFFF_FFFF, 1'b1, ST_OK,        7'd2}},
        '{CMD_PUT,     32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 1'b1, ST_OK,        7'd2}},
        '{CMD_PEEK,    32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'hFFFF_FFFF, 1'b1, ST_OK,        7'd2}},
        '{CMD_PUT,     32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 1'b1, ST_OK,        7'd2}},
        '{CMD_SPARE_5, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 1'b0, ST_OK,        7'd2}},
        '{CMD_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, 1'b0, ST_OK,        7'd2}},
        '{CMD_SPARE_7, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, 1'b0, ST_OK,        7'd2}},
        '{CMD_PUT,     32'h0000_0005, 32'hA5A5_A5A5, 1'b1,
          '{32'hA5A5_A5A5, 1'b0, ST_OK,        7'd3}},
        '{CMD_PUT,     32'hAAAA_AAAA, 32'h5A5A_5A5A, 1'b0, '0},
        '{CMD_PEEK,    32'h1234_5678, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_ERASE,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{32'hFFFF_FFFF, 1'b1, ST_OK,        7'd3}},
        '{CMD_PEEK,    32'h0000_0005, 32'h0000_0000, 1'b0, '0},
        '{CMD_ERASE,   32'h1234_5678, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 1'b0, ST_NOT_FOUND, 7'd3}},
        '{CMD_ERASE,   32'hAAAA_AAAA, 32'h0000_0000, 1'b0, '0},
        '{CMD_ERASE,   32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{CMD_GET,     32'h0000_0005, 32'h0000_0000, 1'b0, '0},
        '{CMD_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, 1'b0, ST_OK,        7'd0}},
        '{CMD_PEEK,    32'h0000_0005, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 1'b0, ST_OK,        7'd0}},
        '{CMD_GET,     32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, 1'b0, ST_OK,        7'd1}},
        '{CMD_CLEAR,   32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts known.
    // ------------------------------------------------------------------
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CMD_W-1:0]        command = CMD_GET;
    logic [KEY_PORT_W-1:0]   key = '0;
    logic [VALUE_PORT_W-1:0] value_in = '0;
    logic                    done;
    logic [VALUE_PORT_W-1:0] value_out;
    logic                    found;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_PORT_W-1:0] entry_count;

    always #5 clk = ~clk;

    linear_search_key_value_map_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key         (key),
        .value_in    (value_in),
        .done        (done),
        .value_out   (value_out),
        .found       (found),
        .status      (status),
        .entry_count (entry_count)
    );

    // ------------------------------------------------------------------
    // Shadow table: the testbench's own copy of the map, updated at the
    // edge where each item is accepted.
    // ------------------------------------------------------------------
    logic [KEY_PORT_W-1:0]   shadow_keys [DEPTH];
    logic [VALUE_PORT_W-1:0] shadow_vals [DEPTH];
    int unsigned             shadow_count = 0;

    // Results still owed by the block, oldest first.
    reply_t      pending_replies [$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    bit          no_gaps = 1'b0;

    // A handful of fixed keys so that random traffic keeps hitting entries.
    logic [KEY_PORT_W-1:0] key_pool [16];

    // Returns the slot holding k, or -1 when k is not in the table.
    function automatic int shadow_find(logic [KEY_PORT_W-1:0] k);
        for (int i = 0; i < int'(shadow_count); i++)
            if (shadow_keys[i] == k)
                return i;
        return -1;
    endfunction

    // Apply one command to the shadow table and return the result it owes.
    function automatic reply_t map_apply(logic [CMD_W-1:0] cmd,
                                         logic [KEY_PORT_W-1:0] k,
                                         logic [VALUE_PORT_W-1:0] v);
        reply_t r;
        int     pos;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_GET, CMD_PUT:
            begin
                pos = shadow_find(k);
                if (pos >= 0)
                begin
                    r.found = 1'b1;
                    if (cmd == CMD_PUT)
                        shadow_vals[pos] = v;
                    r.value = shadow_vals[pos];
                end
                else if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // Append at the tail; get inserts a zero value.
                    shadow_keys[shadow_count] = k;
                    shadow_vals[shadow_count] = (cmd == CMD_PUT) ? v : '0;
                    r.value = shadow_vals[shadow_count];
                    shadow_count++;
                end
            end
            CMD_ERASE:
            begin
                pos = shadow_find(k);
                if (pos >= 0)
                begin
                    r.found = 1'b1;
                    r.value = shadow_vals[pos];
                    // Close the gap: later entries move down one slot.
                    for (int i = pos; i + 1 < int'(shadow_count); i++)
                    begin
                        shadow_keys[i] = shadow_keys[i + 1];
                        shadow_vals[i] = shadow_vals[i + 1];
                    end
                    shadow_count--;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_CLEAR:
                shadow_count = 0;
            CMD_PEEK:
            begin
                pos = shadow_find(k);
                if (pos >= 0)
                begin
                    r.found = 1'b1;
                    r.value = shadow_vals[pos];
                end
            end
            default:
                ;   // spare codes leave the table alone
        endcase
        r.count = COUNT_PORT_W'(shadow_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------

    // Mostly keys already in the table or in the pool, now and then a fresh one.
    function automatic logic [KEY_PORT_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (shadow_count != 0 && r < 5)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        if (r < 8)
            return key_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return CMD_GET;
        if (r < 50)
            return CMD_PUT;
        if (r < 66)
            return CMD_ERASE;
        if (r < 88)
            return CMD_PEEK;
        if (r < 92)
            return CMD_CLEAR;
        case ($urandom_range(0, 2))
            0:       return CMD_SPARE_5;
            1:       return CMD_SPARE_6;
            default: return CMD_SPARE_7;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the edge where the item
    // was taken, with start still high so that a back-to-back item needs
    // no second assignment in that step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [CMD_W-1:0]        cmd,
                             input logic [KEY_PORT_W-1:0]   k,
                             input logic [VALUE_PORT_W-1:0] v,
                             input logic                    typed,
                             input reply_t                  typed_reply);
        int unsigned gap;
        reply_t      predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        command  <= cmd;
        key      <= k;
        value_in <= v;
        // Hold the item until an edge sees start high and busy low.
        do
            @(posedge clk);
        while (busy);
        predicted = map_apply(cmd, k, v);
        pending_replies.push_back(typed ? typed_reply : predicted);
        items_sent++;
    endtask

    // Drop start and hold off until every owed result has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
    endtask

    // A stretch of mixed traffic with random content.
    task automatic run_mix(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_item(pick_command(), pick_key(), $urandom, 1'b0, '0);
    endtask

    // Empty the table, fill it to capacity, push against the full table,
    // then keep working near capacity.
    task automatic run_fill();
        send_item(CMD_CLEAR, $urandom, $urandom, 1'b0, '0);
        while (shadow_count < DEPTH)
            send_item(($urandom_range(0, 3) == 0) ? CMD_GET : CMD_PUT,
                      $urandom, $urandom, 1'b0, '0);
        // Fresh keys now bounce off with a full status; known keys still hit.
        repeat (6)
            send_item(($urandom_range(0, 1) == 0) ? CMD_GET : CMD_PUT,
                      ($urandom_range(0, 2) == 0) ? pick_key() : $urandom,
                      $urandom, 1'b0, '0);
        run_mix(20);
    endtask

    // ------------------------------------------------------------------
    // Result checker. The block drives its outputs from registers, so the
    // values read here at the edge are the ones of the cycle just ending.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with none owed: value %h found %b status %0d count %0d",
                             $realtime, value_out, found, status, entry_count);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (value_out !== want.value || found !== want.found ||
                    status !== want.status || entry_count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch: value %h/%h found %b/%b status %0d/%0d count %0d/%0d (expected/actual)",
                                 $realtime, want.value, value_out, want.found, found,
                                 want.status, status, want.count, entry_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned settle;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 16; i++)
            key_pool[i] = $urandom;

        // Reset once, released on a clock edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, back to back for the first few, gaps afterwards.
        for (int i = 0; i < N_PLAN; i++)
        begin
            no_gaps = (i < 8);
            send_item(PLAN[i].cmd, PLAN[i].key, PLAN[i].value,
                      PLAN[i].typed, PLAN[i].reply);
        end
        drain();

        // Random part in episodes; some run flat out, some fill the table,
        // and now and then the sender waits for the block to empty out.
        while (items_sent < N_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                run_fill();
            else
                run_mix($urandom_range(20, 60));
            if ($urandom_range(0, 4) == 0)
                drain();
        end

        // Wind down: wait for the owed results, bounded, then keep the clock
        // running for anything stray.
        start <= 1'b0;
        settle = 0;
        while (pending_replies.size() != 0 && settle < 4000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
